FILE: hw/rtl/wpf_pkg.sv
// Shared types, constants and coefficient tables for the Wobus function pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpf_pkg;

	// Widths of the fixed-point formats
	localparam int FRAC_BITS = 16;
	localparam int IN_W      = 25;
	localparam int X_W       = 26;
	localparam int ACC_W     = 36;
	localparam int MAG_W     = 32;
	localparam int P2_W      = 40;
	localparam int QUOT_W    = 38;
	localparam int LOW_W     = 38;
	localparam int TERM_W    = 27;
	localparam int RES_W     = 32;
	localparam int QC        = 24;

	// Kelvin constants in Q.16
	localparam logic [IN_W-1:0] K_OFFSET = 25'd19211878;
	localparam logic [IN_W-1:0] K_ZERO_C = 25'd17901158;
	localparam logic [IN_W-1:0] K_14_8   = 25'd969933;
	localparam logic [IN_W-1:0] K_LIMIT  = 25'd32768000;

	// 0.96 in Q24
	localparam logic [24:0] K_096 = 25'd16106127;

	// Quotient numerators in Q24 (shifted up by another 24 bits before division)
	localparam logic [28:0] K_COLD_NUM = 29'd253839278;
	localparam logic [28:0] K_HOT_NUM  = 29'd502142075;

	// Sideband that travels alongside the dividers
	typedef struct packed {
		logic                     hot;
		logic                     big;
		logic                     sat;
		logic signed [TERM_W-1:0] term;
	} wpf_side_t;

	// Horner coefficients scaled by 256^k in Q24; cold table padded with zeros on top
	function automatic logic signed [ACC_W-1:0] coef(input logic hot, input logic [2:0] idx);
		logic signed [ACC_W-1:0] c;
		c = '0;
		if (hot) begin
			unique case (idx)
				3'd0: c = 36'sd16777216;
				3'd1: c = 36'sd15540475;
				3'd2: c = -36'sd14956957;
				3'd3: c = 36'sd139664849;
				3'd4: c = -36'sd439979095;
				3'd5: c = 36'sd726830327;
				3'd6: c = -36'sd594457585;
				3'd7: c = 36'sd201748926;
				default: c = '0;
			endcase
		end else begin
			unique case (idx)
				3'd0: c = 36'sd16777216;
				3'd1: c = -36'sd37974643;
				3'd2: c = 36'sd161783713;
				3'd3: c = -36'sd272242288;
				3'd4: c = -36'sd2349597605;
				3'd5: c = -36'sd7120087744;
				3'd6: c = '0;
				3'd7: c = '0;
				default: c = '0;
			endcase
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wpf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on wpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpf_div
	import wpf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [P2_W-1:0]   in_rem,
	input  wire logic [LOW_W-1:0]  in_low,
	input  wire logic [P2_W-1:0]   in_div,
	input  wire wpf_side_t         in_side,
	output logic                   out_valid,
	output logic [QUOT_W-1:0]      out_quot,
	output logic [P2_W-1:0]        out_div,
	output wpf_side_t              out_side
);

	logic                valid_s [0:QUOT_W];
	logic [P2_W-1:0]     rem_s   [0:QUOT_W];
	logic [LOW_W-1:0]    low_s   [0:QUOT_W];
	logic [P2_W-1:0]     div_s   [0:QUOT_W];
	logic [QUOT_W-1:0]   quot_s  [0:QUOT_W];
	wpf_side_t           side_s  [0:QUOT_W];

	// Stage zero is the registered input of the caller
	assign valid_s[0] = in_valid;
	assign rem_s[0]   = in_rem;
	assign low_s[0]   = in_low;
	assign div_s[0]   = in_div;
	assign quot_s[0]  = '0;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		logic [P2_W:0]   trial;
		logic [P2_W+1:0] diff;
		logic            ge;

		// Shift in the next dividend bit, subtract the divisor when it fits
		assign trial = {rem_s[k], low_s[k][LOW_W-1]};
		assign diff  = {1'b0, trial} - {2'b00, div_s[k]};
		assign ge    = !diff[P2_W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[P2_W-1:0] : trial[P2_W-1:0];
				low_s[k+1]  <= {low_s[k][LOW_W-2:0], 1'b0};
				div_s[k+1]  <= div_s[k];
				quot_s[k+1] <= {quot_s[k][QUOT_W-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = valid_s[QUOT_W];
	assign out_quot  = quot_s[QUOT_W];
	assign out_div   = div_s[QUOT_W];
	assign out_side  = side_s[QUOT_W];

endmodule

`default_nettype wire

FILE: hw/rtl/wobus_polynomial_function_top.sv
// Top level of the Wobus function pipeline: Horner stages, square, two dividers, output.
// Depends on wpf_pkg and wpf_div.
`timescale 1ns / 1ps
`default_nettype none

// Takes one temperature (kelvin, Q.16) per cycle and returns the Wobus function value
// in kelvin, Q.16, with a flag when the value was clipped. The block has no state and
// accepts a new item every cycle unless the output stalls; each item passes through
// one input stage, seven Horner stages (one multiply-add each), magnitude and square
// stages, then two 38-stage bit-serial dividers with a setup stage each, and the output
// register. A stall on the output freezes the whole pipeline; nothing is lost.
module wobus_polynomial_function_top
	import wpf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [IN_W-1:0]  temperature_q16,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [IN_W-1:0]       wobus_q16,
	output logic                  saturated
);

	logic en;
	logic out_valid_q;

	// Advance everything when the output register is free or taken
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// Horner pipeline, stage 0 is the input register
	logic                    hv_s  [0:7];
	logic                    hot_s [0:7];
	logic signed [X_W-1:0]   x_s   [0:7];
	logic signed [ACC_W-1:0] acc_s [0:7];

	logic signed [X_W-1:0] x_in;
	logic                  hot_in;

	assign x_in   = $signed({1'b0, temperature_q16}) - $signed({1'b0, K_OFFSET});
	assign hot_in = !x_in[X_W-1] && (x_in != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_s[0] <= 1'b0;
		end else if (en) begin
			hv_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= x_in;
			hot_s[0] <= hot_in;
			acc_s[0] <= coef(hot_in, 3'd7);
		end
	end

	for (genvar j = 0; j < 7; j++) begin : g_horner
		logic signed [ACC_W+X_W-1:0] prod;

		// acc = c + floor(acc * u / 2^24)
		assign prod = acc_s[j] * x_s[j];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hv_s[j+1] <= 1'b0;
			end else if (en) begin
				hv_s[j+1] <= hv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j+1] <= coef(hot_s[j], 3'(6 - j)) + prod[QC+ACC_W-1:QC];
				x_s[j+1]   <= x_s[j];
				hot_s[j+1] <= hot_s[j];
			end
		end
	end

	// Magnitude of the polynomial and the 0.96 x product
	logic [ACC_W-1:0]        mag_abs;
	logic signed [X_W+25:0]  m096_prod;
	logic                    v_s9;
	logic                    hot_s9;
	logic                    big_s9;
	logic [MAG_W-1:0]        mag_s9;
	logic signed [X_W-1:0]   m096_s9;

	assign mag_abs   = acc_s[7][ACC_W-1] ? ACC_W'(-acc_s[7]) : acc_s[7];
	assign m096_prod = x_s[7] * $signed({1'b0, K_096});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= hv_s[7];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hot_s9  <= hot_s[7];
			big_s9  <= |mag_abs[ACC_W-1:MAG_W];
			mag_s9  <= mag_abs[MAG_W-1:0];
			m096_s9 <= m096_prod[QC+X_W-1:QC];
		end
	end

	// Square the magnitude, fold the offsets into one term
	logic [2*MAG_W-1:0]       sq;
	logic signed [TERM_W-1:0] hot_term;
	logic                     v_s10;
	logic                     hot_s10;
	logic                     big_s10;
	logic [P2_W-1:0]          p2_s10;
	logic signed [TERM_W-1:0] term_s10;

	assign sq       = mag_s9 * mag_s9;
	assign hot_term = TERM_W'(m096_s9) - $signed({2'b00, K_14_8})
		+ $signed({2'b00, K_ZERO_C});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hot_s10  <= hot_s9;
			big_s10  <= big_s9;
			p2_s10   <= sq[QC+P2_W-1:QC];
			term_s10 <= hot_s9 ? hot_term : $signed({2'b00, K_ZERO_C});
		end
	end

	// Set up the first division, flag an oversized quotient or a zero divisor
	logic [28:0]     num_k;
	logic [P2_W-1:0] r1_init;
	logic            v_s11;
	logic [P2_W-1:0] rem_s11;
	logic [LOW_W-1:0] low_s11;
	logic [P2_W-1:0] div_s11;
	wpf_side_t       side_s11;

	assign num_k   = hot_s10 ? K_HOT_NUM : K_COLD_NUM;
	assign r1_init = P2_W'(num_k[28:14]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s11       <= r1_init;
			low_s11       <= {num_k[13:0], 24'd0};
			div_s11       <= p2_s10;
			side_s11.hot  <= hot_s10;
			side_s11.big  <= big_s10;
			side_s11.sat  <= !big_s10 && (r1_init >= p2_s10);
			side_s11.term <= term_s10;
		end
	end

	logic              d1_valid;
	logic [QUOT_W-1:0] d1_quot;
	logic [P2_W-1:0]   d1_div;
	wpf_side_t         d1_side;

	wpf_div u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s11),
		.in_rem    (rem_s11),
		.in_low    (low_s11),
		.in_div    (div_s11),
		.in_side   (side_s11),
		.out_valid (d1_valid),
		.out_quot  (d1_quot),
		.out_div   (d1_div),
		.out_side  (d1_side)
	);

	// Set up the second division on the first quotient
	logic [P2_W-1:0]  r2_init;
	logic             v_s50;
	logic [P2_W-1:0]  rem_s50;
	logic [LOW_W-1:0] low_s50;
	logic [P2_W-1:0]  div_s50;
	wpf_side_t        side_s50;

	assign r2_init = P2_W'(d1_quot[QUOT_W-1:14]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s50 <= 1'b0;
		end else if (en) begin
			v_s50 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s50       <= r2_init;
			low_s50       <= {d1_quot[13:0], 24'd0};
			div_s50       <= d1_div;
			side_s50.hot  <= d1_side.hot;
			side_s50.big  <= d1_side.big;
			side_s50.sat  <= d1_side.sat || (!d1_side.big && (r2_init >= d1_div));
			side_s50.term <= d1_side.term;
		end
	end

	logic              d2_valid;
	logic [QUOT_W-1:0] d2_quot;
	logic [P2_W-1:0]   d2_div;
	wpf_side_t         d2_side;

	wpf_div u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s50),
		.in_rem    (rem_s50),
		.in_low    (low_s50),
		.in_div    (div_s50),
		.in_side   (side_s50),
		.out_valid (d2_valid),
		.out_quot  (d2_quot),
		.out_div   (d2_div),
		.out_side  (d2_side)
	);

	// Add the offsets, clip to the output range
	logic [QUOT_W-9:0]       q_frac;
	logic signed [RES_W-1:0] res;
	logic [IN_W-1:0]         wobus_q;
	logic                    sat_q;
	logic [IN_W-1:0]         res_out;
	logic                    res_clip;

	assign q_frac = (d2_side.big || (d2_div == '0 && d2_side.sat)) ? '0 : d2_quot[QUOT_W-1:8];
	assign res    = $signed({2'b00, q_frac}) + RES_W'(d2_side.term);

	always_comb begin
		res_out  = res[IN_W-1:0];
		res_clip = 1'b0;
		priority if (d2_side.sat) begin
			res_out  = K_LIMIT;
			res_clip = 1'b1;
		end else if (res > $signed({7'd0, K_LIMIT})) begin
			res_out  = K_LIMIT;
			res_clip = 1'b1;
		end else if (res < 0) begin
			res_out  = '0;
			res_clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wobus_q <= res_out;
			sat_q   <= res_clip;
		end
	end

	assign out_valid = out_valid_q;
	assign wobus_q16 = wobus_q;
	assign saturated = sat_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking bench for the Wobus function pipeline: random and edge temperatures in,
// results compared against an in-bench fixed-point predictor. Depends on wpf_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
	import wpf_pkg::*;

	typedef struct {
		logic [IN_W-1:0] wobus;
		logic            sat;
	} wobus_res_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [IN_W-1:0] temperature_q16;
	logic            out_valid;
	logic            out_stall;
	logic [IN_W-1:0] wobus_q16;
	logic            saturated;

	logic [IN_W-1:0] temp_pending[$];
	wobus_res_t      wobus_expected[$];
	int              fail_count;
	int              idle_cycles;
	bit              stim_done;
	bit              calm_mode;
	bit              hold_sender;
	bit              long_hold_req;
	bit              in_accepted;

	wobus_polynomial_function_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.temperature_q16(temperature_q16),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.wobus_q16      (wobus_q16),
		.saturated      (saturated)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Floor shift of a signed value
	function automatic longint floor_shr(input longint v, input int k);
		if (v >= 0)
			return v >>> k;
		return -((-(v + 1)) >>> k) - 1;
	endfunction

	// Predict one result from a temperature
	function automatic wobus_res_t predict_wobus(input logic [IN_W-1:0] temp);
		wobus_res_t r;
		longint     x, u, acc, res, lim, cf;
		longint unsigned mag, p2, num, t1, q;
		bit         hot, sat, clip;
		int         i, top;
		x    = longint'(temp) - longint'(K_OFFSET);
		sat  = 0;
		clip = 0;
		q    = 0;
		if (x > (longint'(320) << FRAC_BITS))
			x = longint'(320) << FRAC_BITS;
		if (x < -(longint'(320) << FRAC_BITS))
			x = -(longint'(320) << FRAC_BITS);
		hot = x > 0;
		u   = x;
		// Horner evaluation in Q24
		top = hot ? 7 : 5;
		acc = longint'(coef(hot, 3'(top)));
		for (i = top - 1; i >= 0; i--) begin
			cf  = longint'(coef(hot, 3'(i)));
			acc = cf + floor_shr(acc * u, QC);
		end
		mag = acc < 0 ? longint'(-acc) : acc;
		num = (hot ? longint'(K_HOT_NUM) : longint'(K_COLD_NUM)) << QC;
		// Quotient C / p^4 by two divisions
		if (mag < (64'd1 << 32)) begin
			p2 = (mag * mag) >> QC;
			if (p2 == 0) begin
				sat = 1;
			end else begin
				t1 = num / p2;
				if (t1 >= (64'd1 << 38)) begin
					sat = 1;
				end else begin
					q = (t1 << QC) / p2;
					if (q >= (64'd1 << 38))
						sat = 1;
				end
			end
		end
		lim = longint'(K_LIMIT);
		if (sat) begin
			res  = lim;
			clip = 1;
		end else begin
			res = longint'(q >> (QC - FRAC_BITS)) + longint'(K_ZERO_C);
			if (hot)
				res += floor_shr(x * longint'(K_096), QC) - longint'(K_14_8);
			if (res > lim) begin
				res  = lim;
				clip = 1;
			end else if (res < 0) begin
				res  = 0;
				clip = 1;
			end
		end
		r.wobus = res[IN_W-1:0];
		r.sat   = clip;
		return r;
	endfunction

	// Driver: offer pending items at the falling edge, with random gaps
	int gap_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid        <= 1'b0;
			temperature_q16 <= '0;
			gap_left        = 0;
		end else if (!in_valid || in_accepted) begin
			if (in_valid) begin
				void'(temp_pending.pop_front());
			end
			if (gap_left == 0 && !calm_mode && $urandom_range(0, 9) == 0)
				gap_left = $urandom_range(1, 4);
			if (hold_sender || temp_pending.size() == 0 || gap_left > 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				in_valid        <= 1'b1;
				temperature_q16 <= temp_pending[0];
			end
		end
	end

	// Record expectations for each input transfer
	always @(posedge clk) begin
		in_accepted = arst_n && in_valid && !in_stall;
		if (in_accepted)
			wobus_expected.push_back(predict_wobus(temperature_q16));
	end

	// Receiver stall: random bursts, plus one long hold-off on request
	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (long_hold_req && stall_left == 0) begin
				stall_left    = 200;
				long_hold_req = 0;
			end else if (stall_left == 0 && !calm_mode && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 4);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Monitor: compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		wobus_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (wobus_expected.size() == 0) begin
				$error("unexpected result wobus_q16=%0d saturated=%0d", wobus_q16, saturated);
				fail_count++;
			end else begin
				e = wobus_expected.pop_front();
				if (wobus_q16 !== e.wobus) begin
					$error("wobus_q16 expected %0d actual %0d", e.wobus, wobus_q16);
					fail_count++;
				end
				if (saturated !== e.sat) begin
					$error("saturated expected %0d actual %0d", e.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("[wobus_polynomial_function_top] ERROR");
			$finish;
		end
	end

	// Random temperature: half across 0 to 400 K, the rest near the branch point or anywhere in the input span
	function automatic logic [IN_W-1:0] rand_temp();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return IN_W'($urandom_range(0, 26214400));
		if (sel < 8)
			return IN_W'(int'(K_OFFSET) + $urandom_range(0, 400000) - 200000);
		return IN_W'($urandom);
	endfunction

	initial begin
		logic [IN_W-1:0] directed[$];
		int i;
		fail_count    = 0;
		idle_cycles   = 0;
		stim_done     = 0;
		calm_mode     = 0;
		hold_sender   = 0;
		long_hold_req = 0;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extremes, around the branch point, overflow region, full input span
		directed = '{25'd0, 25'd1, 25'd26214400, 25'h1FFFFFF, 25'h1000000, 25'h0AAAAAA,
			25'h1555555, K_OFFSET, K_OFFSET - 25'd1, K_OFFSET + 25'd1, K_OFFSET + 25'd2,
			K_ZERO_C, 25'd16384000, 25'd9830400, 25'd6553600, 25'd13107200, 25'd22937600,
			25'd20971520, 25'd32768000, 25'd3276800};
		foreach (directed[j])
			temp_pending.push_back(directed[j]);

		// Random part, with a long receiver hold-off while the sender keeps offering
		for (i = 0; i < 300; i++)
			temp_pending.push_back(rand_temp());
		long_hold_req = 1;
		wait (temp_pending.size() == 0);

		// Sender pause until everything has drained
		hold_sender = 1;
		wait (wobus_expected.size() == 0 && !out_valid);
		@(negedge clk);
		hold_sender = 0;

		for (i = 0; i < 280; i++)
			temp_pending.push_back(rand_temp());
		wait (temp_pending.size() == 0);

		// Last part with no idling on either side
		calm_mode = 1;
		for (i = 0; i < 100; i++)
			temp_pending.push_back(rand_temp());
		wait (temp_pending.size() == 0 && !in_valid);
		wait (wobus_expected.size() == 0);
		repeat (100) @(posedge clk);

		if (fail_count == 0)
			$display("[wobus_polynomial_function_top] OK");
		else
			$display("[wobus_polynomial_function_top] ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/wpf_pkg.sv
hw/rtl/wpf_div.sv
hw/rtl/wobus_polynomial_function_top.sv
tb/sv/tb.sv
